// ===== rtl/dst_pkg.sv =====
`default_nettype none
package dst_pkg;

	localparam int SLOTS_DEF = 64;
	localparam int KEY_W     = 64;
	localparam int BLK_W     = 64;
	localparam int IDX_W     = 6;

	typedef enum logic [1:0] {
		FN_FIND = 2'd0,
		FN_ADD  = 2'd1,
		FN_DEL  = 2'd2,
		FN_SORT = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EXISTS   = 2'd1,
		ST_NO_SPACE = 2'd2,
		ST_NOT_FND  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RD_I   = 2'd0,
		RD_J   = 2'd1,
		RD_PM1 = 2'd2
	} rd_src_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SJ,
		S_SJ_LD,
		S_SP,
		S_SP_CHK,
		S_SPUT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic        del;
		logic [KEY_W-1:0] key;
		logic [BLK_W-1:0] blk;
	} entry_t;

	typedef struct packed {
		logic    load;
		logic    rd_en;
		rd_src_t rd_src;
		logic    mark_free;
		logic    inc_i;
		logic    hit_res;
		logic    miss_res;
		logic    sort_res;
		logic    j_init;
		logic    j_inc;
		logic    hold_ld;
		logic    p_dec;
		logic    wr_shift;
		logic    wr_hold;
		logic    out_ld;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  i_end;
		logic  hit;
		logic  rd_del;
		logic  j_done;
		logic  p_zero;
		logic  ahead;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/dst_req_if.sv =====
`default_nettype none
interface dst_req_if;
	import dst_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [KEY_W-1:0]  name_key;
	logic [BLK_W-1:0]  start_block;
	modport source (output valid, func, name_key, start_block, input ready);
	modport sink (input valid, func, name_key, start_block, output ready);
endinterface
`default_nettype wire

// ===== rtl/dst_rsp_if.sv =====
`default_nettype none
interface dst_rsp_if;
	import dst_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [IDX_W-1:0]  slot_index;
	logic [BLK_W-1:0]  found_block;
	modport source (output valid, status, slot_index, found_block, input ready);
	modport sink (input valid, status, slot_index, found_block, output ready);
endinterface
`default_nettype wire

// ===== rtl/dst_ctrl.sv =====
`default_nettype none
module dst_ctrl
	import dst_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;
	logic   out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_ld) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_vld_q;
	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rd_src = RD_I;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (sts.func == FN_SORT) begin
					cmd.j_init = 1'b1;
					state_d    = S_SJ;
				end else if (sts.i_end) begin
					cmd.miss_res = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (sts.hit) begin
					cmd.hit_res = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.mark_free = sts.rd_del;
					cmd.inc_i     = 1'b1;
					state_d       = S_SCAN_RD;
				end
			end
			S_SJ: begin
				if (sts.j_done) begin
					cmd.sort_res = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RD_J;
					state_d    = S_SJ_LD;
				end
			end
			S_SJ_LD: begin
				cmd.hold_ld = 1'b1;
				state_d     = S_SP;
			end
			S_SP: begin
				if (sts.p_zero) begin
					state_d = S_SPUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_src = RD_PM1;
					state_d    = S_SP_CHK;
				end
			end
			S_SP_CHK: begin
				if (sts.ahead) begin
					cmd.wr_shift = 1'b1;
					cmd.p_dec    = 1'b1;
					state_d      = S_SP;
				end else begin
					state_d = S_SPUT;
				end
			end
			S_SPUT: begin
				cmd.wr_hold = 1'b1;
				cmd.j_inc   = 1'b1;
				state_d     = S_SJ;
			end
			S_DONE: begin
				if (!out_vld_q || rsp_ready) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE)
		else $error("load outside idle");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == S_DONE)
		else $error("result word without finished operation");
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_shift && cmd.wr_hold))
		else $error("two writes in one cycle");

endmodule
`default_nettype wire

// ===== rtl/dst_dp.sv =====
`default_nettype none
module dst_dp
	import dst_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	output sts_t                  sts,
	input  wire logic [1:0]       in_func,
	input  wire logic [KEY_W-1:0] in_key,
	input  wire logic [BLK_W-1:0] in_blk,
	output logic [1:0]            out_status,
	output logic [IDX_W-1:0]      out_idx,
	output logic [BLK_W-1:0]      out_blk
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	entry_t mem [SLOTS];

	func_t            func_q;
	logic [KEY_W-1:0] key_q;
	logic [BLK_W-1:0] blk_q;
	logic [CW-1:0]    n_q, i_q, j_q, p_q;
	logic [IW-1:0]    free_q;
	logic             free_vld_q;
	entry_t           rd_q, hold_q;
	status_t          res_status_q;
	logic [IDX_W-1:0] res_idx_q;
	logic [BLK_W-1:0] res_blk_q;

	logic [IW-1:0]    rd_addr, wr_addr;
	logic             wr_en, n_inc;
	entry_t           wr_data;
	logic [CW-1:0]    pm1;

	assign pm1 = p_q - CW'(1);

	always_comb begin
		case (cmd.rd_src)
			RD_I:    rd_addr = i_q[IW-1:0];
			RD_J:    rd_addr = j_q[IW-1:0];
			RD_PM1:  rd_addr = pm1[IW-1:0];
			default: rd_addr = i_q[IW-1:0];
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = p_q[IW-1:0];
		wr_data = hold_q;
		n_inc   = 1'b0;
		if (cmd.hit_res && func_q == FN_DEL) begin
			wr_en   = 1'b1;
			wr_addr = i_q[IW-1:0];
			wr_data = '{del: 1'b1, key: rd_q.key, blk: rd_q.blk};
		end else if (cmd.miss_res && func_q == FN_ADD) begin
			wr_data = '{del: 1'b0, key: key_q, blk: blk_q};
			if (free_vld_q) begin
				wr_en   = 1'b1;
				wr_addr = free_q;
			end else if (n_q < CW'(SLOTS)) begin
				wr_en   = 1'b1;
				wr_addr = n_q[IW-1:0];
				n_inc   = 1'b1;
			end
		end else if (cmd.wr_shift) begin
			wr_en   = 1'b1;
			wr_data = rd_q;
		end else if (cmd.wr_hold) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q        <= '0;
			i_q        <= '0;
			j_q        <= '0;
			p_q        <= '0;
			free_vld_q <= 1'b0;
		end else begin
			if (n_inc) begin
				n_q <= n_q + CW'(1);
			end
			if (cmd.load) begin
				i_q        <= '0;
				free_vld_q <= 1'b0;
			end else begin
				if (cmd.inc_i) begin
					i_q <= i_q + CW'(1);
				end
				if (cmd.mark_free && !free_vld_q) begin
					free_vld_q <= 1'b1;
				end
			end
			if (cmd.j_init) begin
				j_q <= CW'(1);
			end else if (cmd.j_inc) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.hold_ld) begin
				p_q <= j_q;
			end else if (cmd.p_dec) begin
				p_q <= pm1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(in_func);
			key_q  <= in_key;
			blk_q  <= in_blk;
		end
		if (cmd.mark_free && !free_vld_q) begin
			free_q <= i_q[IW-1:0];
		end
		if (cmd.hold_ld) begin
			hold_q <= rd_q;
		end
		if (cmd.hit_res) begin
			res_idx_q <= IDX_W'(i_q);
			case (func_q)
				FN_ADD: begin
					res_status_q <= ST_EXISTS;
					res_blk_q    <= '0;
				end
				FN_DEL: begin
					res_status_q <= ST_OK;
					res_blk_q    <= '0;
				end
				default: begin
					res_status_q <= ST_OK;
					res_blk_q    <= rd_q.blk;
				end
			endcase
		end else if (cmd.miss_res) begin
			res_blk_q <= '0;
			if (func_q == FN_ADD) begin
				if (free_vld_q) begin
					res_status_q <= ST_OK;
					res_idx_q    <= IDX_W'(free_q);
				end else if (n_q < CW'(SLOTS)) begin
					res_status_q <= ST_OK;
					res_idx_q    <= IDX_W'(n_q);
				end else begin
					res_status_q <= ST_NO_SPACE;
					res_idx_q    <= '0;
				end
			end else begin
				res_status_q <= ST_NOT_FND;
				res_idx_q    <= '0;
			end
		end else if (cmd.sort_res) begin
			res_status_q <= ST_OK;
			res_idx_q    <= '0;
			res_blk_q    <= '0;
		end
		if (cmd.out_ld) begin
			out_status <= res_status_q;
			out_idx    <= res_idx_q;
			out_blk    <= res_blk_q;
		end
	end

	always_comb begin
		sts.func   = func_q;
		sts.i_end  = (i_q == n_q);
		sts.hit    = !rd_q.del && (rd_q.key == key_q);
		sts.rd_del = rd_q.del;
		sts.j_done = (j_q >= n_q);
		sts.p_zero = (p_q == '0);
		sts.ahead  = !hold_q.del && (rd_q.del || (hold_q.blk < rd_q.blk));
	end

	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(SLOTS))
		else $error("fill count past table size");
	a_i_range: assert property (@(posedge clk) disable iff (!arst_n)
		i_q <= n_q)
		else $error("scan index past end tag");
	a_n_step: assert property (@(posedge clk) disable iff (!arst_n)
		n_q != $past(n_q) |-> n_q == $past(n_q) + CW'(1))
		else $error("fill count moved by other than one");

endmodule
`default_nettype wire

// ===== rtl/directory_slot_table.sv =====
// channel  modport  word fields
// req      sink     func, name_key, start_block
// rsp      source   status, slot_index, found_block
//
// find, add and delete read and check the slots one by one up to the end tag
// sort runs an insertion sort over the slots in use, one compare-and-shift step at a time,
// and in the worst case its number of steps grows with the square of the slots in use
// reset empties the table at once through the fill count, no clearing pass
// one word in flight; a waiting result word does not block acceptance of the next
`default_nettype none
module directory_slot_table
	import dst_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	dst_req_if.sink  req,
	dst_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;

	dst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	dst_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_func    (req.func),
		.in_key     (req.name_key),
		.in_blk     (req.start_block),
		.out_status (rsp.status),
		.out_idx    (rsp.slot_index),
		.out_blk    (rsp.found_block)
	);

endmodule
`default_nettype wire
